FILE: rtl/b64d_pkg.sv
// Shared types, constants and the character map of the base64 stream decoder.
package b64d_pkg;

	// Default depth of the queue between the front and back parts.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
	localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;

	// Sextet values with a meaning of their own.
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] SEXTET_BAD   = 6'd63;
	localparam logic [7:0] LOWER_OFFSET = 8'd26;
	localparam logic [7:0] DIGIT_OFFSET = 8'd52;

	// One queue entry: the bytes of a finished group, packed from slot zero up,
	// followed by the terminating result when the string ends.
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            eot;
	} b64d_entry_t;

	// Queue status seen by the front and back parts.
	typedef struct packed {
		logic full;
		logic empty;
	} b64d_qstat_t;

	// Maps a character to {invalid, value}; an invalid character reads as 63.
	function automatic logic [6:0] sextet_of(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'd0;
		if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
			v = ch - CHAR_UPPER_A;
			return {1'b0, v[5:0]};
		end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
			v = ch - CHAR_LOWER_A + LOWER_OFFSET;
			return {1'b0, v[5:0]};
		end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
			v = ch - CHAR_DIGIT_0 + DIGIT_OFFSET;
			return {1'b0, v[5:0]};
		end else if (ch == CHAR_PLUS) begin
			return {1'b0, SEXTET_PLUS};
		end else if (ch == CHAR_SLASH) begin
			return {1'b0, SEXTET_SLASH};
		end else if (ch == CHAR_PAD) begin
			return 7'd0;
		end
		return {1'b1, SEXTET_BAD};
	endfunction

endpackage

FILE: rtl/b64d_front.sv
// Front part: accepts characters, tracks the group and queues the results it causes.
module b64d_front import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        has_char,
	input  logic        end_of_string,
	input  b64d_qstat_t qstat,
	output logic        push,
	output b64d_entry_t push_entry
);

	logic [1:0] pos_q;
	logic [5:0] s1_q, s2_q, s3_q;
	logic       sup3_q;
	logic       stopped_q;
	logic       head_bad_q;

	logic       accept;
	logic [6:0] lookup;
	logic       bad;
	logic       is_pad;
	logic       take_char;
	logic       group_emit;
	logic       keep_second;
	logic       keep_third;
	logic [7:0] byte0, byte1, byte2;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	// Character classification.
	assign lookup    = sextet_of(char_code);
	assign bad       = lookup[6];
	assign is_pad    = (char_code == CHAR_PAD);
	assign take_char = accept && has_char && !stopped_q;

	// A fourth character with a clean head completes a group that emits bytes.
	assign group_emit  = take_char && (pos_q == 2'd3) && !head_bad_q;
	assign keep_second = !sup3_q;
	assign keep_third  = !(bad || is_pad);

	assign byte0 = {s1_q, s2_q[5:4]};
	assign byte1 = {s2_q[3:0], s3_q[5:2]};
	assign byte2 = {s3_q[1:0], lookup[5:0]};

	// Queue entry with the present bytes packed from slot zero.
	always_comb begin
		push_entry.bytes[0] = byte0;
		push_entry.bytes[1] = keep_second ? byte1 : byte2;
		push_entry.bytes[2] = byte2;
		push_entry.nbytes   = group_emit
			? (2'd1 + {1'b0, keep_second} + {1'b0, keep_third}) : 2'd0;
		push_entry.eot      = end_of_string;
	end

	assign push = accept && (group_emit || end_of_string);

	// Group state; the string end returns everything to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 2'd0;
			s1_q       <= 6'd0;
			s2_q       <= 6'd0;
			s3_q       <= 6'd0;
			sup3_q     <= 1'b0;
			stopped_q  <= 1'b0;
			head_bad_q <= 1'b0;
		end else if (accept && end_of_string) begin
			pos_q      <= 2'd0;
			s1_q       <= 6'd0;
			s2_q       <= 6'd0;
			s3_q       <= 6'd0;
			sup3_q     <= 1'b0;
			stopped_q  <= 1'b0;
			head_bad_q <= 1'b0;
		end else if (take_char) begin
			pos_q <= pos_q + 2'd1;
			unique case (pos_q)
				2'd0: begin
					s1_q       <= lookup[5:0];
					head_bad_q <= bad;
				end
				2'd1: begin
					s2_q       <= lookup[5:0];
					head_bad_q <= head_bad_q || bad;
				end
				2'd2: begin
					s3_q   <= lookup[5:0];
					sup3_q <= bad || is_pad;
				end
				default: begin
					if (head_bad_q) begin
						stopped_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/b64d_queue.sv
// Short queue of result entries between the front and back parts.
module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  b64d_entry_t wdata,
	input  logic        rd,
	output b64d_entry_t rdata,
	output b64d_qstat_t qstat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64d_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign qstat.full  = (count_q == CNT_FULL);
	assign qstat.empty = (count_q == '0);
	assign do_wr = wr && !qstat.full;
	assign do_rd = rd && !qstat.empty;
	assign rdata = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/b64d_back.sv
// Back part: unpacks queue entries into single results behind an output register.
module b64d_back import b64d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  b64d_qstat_t qstat,
	input  b64d_entry_t head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        end_of_text,
	output logic        last_of_run
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       eot_q;
	logic       last_q;

	logic       load;
	logic [2:0] total;
	logic       cur_last;
	logic       cur_eot;
	logic [7:0] cur_byte;

	// Pick the result at the current slot of the head entry.
	assign total    = {1'b0, head.nbytes} + {2'b0, head.eot};
	assign cur_last = ({1'b0, idx_q} + 3'd1 == total);
	assign cur_eot  = (idx_q == head.nbytes);
	assign cur_byte = (cur_eot || idx_q == 2'd3) ? 8'd0 : head.bytes[idx_q];

	assign load = !qstat.empty && (!valid_q || out_ready);
	assign pop  = load && cur_last;

	// Slot counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= cur_last ? 2'd0 : idx_q + 2'd1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= cur_byte;
			eot_q  <= cur_eot;
			last_q <= cur_last;
		end
	end

	assign out_valid   = valid_q;
	assign data_byte   = byte_q;
	assign end_of_text = eot_q;
	assign last_of_run = last_q;

endmodule

FILE: rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front part, result queue and back part.
//
// Channel  Dir  Signals                      Contents
// s_*      in   tvalid tready tdata tuser    char_code, has_char, end_of_string
//               tlast
// m_*      out  tvalid tready tdata tuser    data_byte, end_of_text, last_of_run
//               tlast
//
// One character is accepted every cycle while the queue has room; the front part
// does a group's work in the cycle of its fourth character.
// The back part sends one result per cycle from the queue while m_tready is high;
// a group gives up to three results and a string end with a group up to four.
// An item's first result is registered in the queue, then in the output register.
// Reset is asynchronous and clears the group state, queue and output valid.
// Output stalls fill the queue (QUEUE_DEPTH entries) before s_tready falls.
module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tuser,   // [0] has_char
	input  logic       s_tlast,   // end_of_string
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic       m_tuser,   // [0] end_of_text
	output logic       m_tlast    // last_of_run
);

	b64d_qstat_t qstat;
	b64d_entry_t push_entry;
	b64d_entry_t head;
	logic        push;
	logic        pop;

	b64d_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.char_code     (s_tdata),
		.has_char      (s_tuser),
		.end_of_string (s_tlast),
		.qstat         (qstat),
		.push          (push),
		.push_entry    (push_entry)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wdata  (push_entry),
		.rd     (pop),
		.rdata  (head),
		.qstat  (qstat)
	);

	b64d_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qstat       (qstat),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.data_byte   (m_tdata),
		.end_of_text (m_tuser),
		.last_of_run (m_tlast)
	);

`ifndef SYNTHESIS
	// The terminating result is always the last of its run.
	a_eot_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("terminating result not marked last");

	// The terminating result carries a zero byte.
	a_eot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'd0)
		else $error("terminating result carries data");

	// A new result only appears when the queue held an entry.
	a_load_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!qstat.empty))
		else $error("result produced from an empty queue");

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into a full queue");
`endif

endmodule
